FILE: hdl/sbt_pkg.sv
// Package for the sticky box tracker: codes, states and constants.
// Used by sticky_box_tracker_iou_ttl and its testbench.
package sbt_pkg;

    localparam int MaxRegions = 16;
    localparam int IdxW       = $clog2(MaxRegions);
    localparam int CntW       = $clog2(MaxRegions + 1);
    localparam int EntryW     = 64 + 4 + 32;

    localparam logic [9:0]  NumReset  = 10'd3;
    localparam logic [9:0]  DenReset  = 10'd10;
    localparam logic [31:0] HoldReset = 32'd2500;

    localparam logic [1:0] RegNum  = 2'd0;
    localparam logic [1:0] RegDen  = 2'd1;
    localparam logic [1:0] RegHold = 2'd2;

    localparam logic [1:0] CmdDetect = 2'd0;
    localparam logic [1:0] CmdSweep  = 2'd1;
    localparam logic [1:0] CmdClear  = 2'd2;

    localparam logic [2:0] StMerged   = 3'd0;
    localparam logic [2:0] StInserted = 3'd1;
    localparam logic [2:0] StDropped  = 3'd2;
    localparam logic [2:0] StRegion   = 3'd3;
    localparam logic [2:0] StEmpty    = 3'd4;
    localparam logic [2:0] StCleared  = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_DRD, S_DWAIT, S_AREA, S_INTER, S_MUL1, S_MUL2, S_DEC, S_DWR,
        S_SRD, S_SWAIT, S_SCHK, S_EMIT, S_EWAIT, S_OUT
    } t_state;

endpackage

FILE: hdl/sticky_box_tracker_iou_ttl.sv
// Sticky box tracker top level: sequencer, shared multiplier and table RAM.
// Depends on sbt_pkg and sbt_ram.
//
// Usage: items enter on the s_axis channel (command, time, box, label) and
// results leave on m_axis; tlast marks the last result caused by an item.
// The table lives in one RAM of MaxRegions entries with registered reads.
// A detection walks the table one entry at a time; for each entry, both
// areas, the intersection and the two cross products pass through one
// shared 34 by 34 bit multiplier, in the states S_DRD, S_DWAIT, S_AREA,
// S_INTER, S_MUL1, S_MUL2 and S_DEC. The walk stops at the first matching
// entry or after the last one; S_DWR sets the result and S_OUT offers it.
// A sweep reads each entry, checks its age and writes survivors back
// compacted; each result is then read through S_EWAIT and offered in S_OUT,
// or a single empty result is offered if no entry survives.
// A clear offers its result in the cycle after it is taken. Command 3 is
// accepted and gives no result. s_axis_tready is high only while the
// sequencer is idle, which it returns to after each last result is taken.
// A stalled receiver holds the block in its output state; nothing is lost.
// Reset empties the table (count to zero) and loads the register defaults;
// it needs no clearing pass. Configuration writes are taken any cycle.
module sticky_box_tracker_iou_ttl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: command[1:0], current_time[33:2], left[49:34], top[65:50],
    //        right[81:66], bottom[97:82], label_code[101:98], zero to 103
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: status[2:0], out_left[18:3], out_top[34:19], out_right[50:35],
    //        out_bottom[66:51], out_label[70:67], zero to 71
    output logic [71:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import sbt_pkg::*;

    t_state r_state, n_state;

    logic [9:0]  r_num, r_den;
    logic [31:0] r_hold;
    logic [CntW-1:0] r_count, n_count;
    logic [CntW-1:0] r_idx, r_kept, r_nemit;
    logic [1:0]  r_cmd;
    logic [31:0] r_now;
    logic signed [15:0] r_nb [4];
    logic [3:0]  r_lab;

    logic signed [63:0] r_area_n, r_area_e, r_inter, r_lhs;
    logic signed [33:0] r_ma, r_mb;
    logic        r_ovl;
    logic [71:0] r_odata;
    logic        r_olast;

    // Shared multiplier: registered operands loaded each step, product used in the following state.
    logic signed [67:0] w_prod;
    assign w_prod = r_ma * r_mb;

    logic              w_we;
    logic [IdxW-1:0]   w_waddr, w_raddr;
    logic [EntryW-1:0] w_wdata, w_rdata;

    sbt_ram #(.Width(EntryW), .Depth(MaxRegions)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    logic signed [15:0] e_b [4];
    logic [3:0]  e_lab;
    logic [31:0] e_time;
    assign e_b[0] = w_rdata[15:0];
    assign e_b[1] = w_rdata[31:16];
    assign e_b[2] = w_rdata[47:32];
    assign e_b[3] = w_rdata[63:48];
    assign e_lab  = w_rdata[67:64];
    assign e_time = w_rdata[99:68];

    logic signed [16:0] w_il, w_it, w_ir, w_ib;
    assign w_il = (e_b[0] > r_nb[0]) ? e_b[0] : r_nb[0];
    assign w_it = (e_b[1] > r_nb[1]) ? e_b[1] : r_nb[1];
    assign w_ir = (e_b[2] < r_nb[2]) ? e_b[2] : r_nb[2];
    assign w_ib = (e_b[3] < r_nb[3]) ? e_b[3] : r_nb[3];

    logic signed [63:0] w_union;
    assign w_union = r_area_n + r_area_e - r_inter;
    logic w_match;
    assign w_match = r_ovl && (w_union > 64'sd0) && (r_lhs >= 64'(w_prod));

    logic [31:0] w_age;
    assign w_age = r_now - e_time;
    logic w_keep;
    assign w_keep = (w_age <= r_hold);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (s_axis_tvalid) begin
                case (s_axis_tdata[1:0])
                    CmdDetect: n_state = S_DRD;
                    CmdSweep:  n_state = S_SRD;
                    CmdClear:  n_state = S_OUT;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_DRD:   n_state = (r_idx == r_count) ? S_DWR : S_DWAIT;
            S_DWAIT: n_state = S_AREA;
            S_AREA:  n_state = S_INTER;
            S_INTER: n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_DEC;
            S_DEC:   n_state = w_match ? S_DWR : S_DRD;
            S_DWR:   n_state = S_OUT;
            S_SRD:   n_state = (r_idx == r_count) ? S_EMIT : S_SWAIT;
            S_SWAIT: n_state = S_SCHK;
            S_SCHK:  n_state = S_SRD;
            S_EMIT:  n_state = (r_kept == '0) ? S_OUT : S_EWAIT;
            S_EWAIT: n_state = S_OUT;
            S_OUT:   if (m_axis_tready) begin
                if (r_cmd == CmdSweep && !r_olast) n_state = S_EWAIT;
                else n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_raddr = r_idx[IdxW-1:0];
        // The emit pass reads the compacted table at the next result's index.
        if (r_state inside {S_EMIT, S_EWAIT, S_OUT})
            w_raddr = r_nemit[IdxW-1:0];
        w_we    = 1'b0;
        w_waddr = r_idx[IdxW-1:0];
        w_wdata = {r_now, r_lab, r_nb[3], r_nb[2], r_nb[1], r_nb[0]};
        if (r_state == S_DWR) w_we = (r_idx < r_count) || (r_count != CntW'(MaxRegions));
        if (r_state == S_SCHK && w_keep) begin
            w_we    = 1'b1;
            w_waddr = r_kept[IdxW-1:0];
            w_wdata = w_rdata;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    always_comb begin
        n_count = r_count;
        if (r_state == S_DWR && r_idx == r_count && r_count != CntW'(MaxRegions))
            n_count = r_count + 1'b1;
        if (r_state == S_EMIT) n_count = r_kept;
        if (r_state == S_IDLE && s_axis_tvalid && s_axis_tdata[1:0] == CmdClear)
            n_count = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_num   <= NumReset;
            r_den   <= DenReset;
            r_hold  <= HoldReset;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    RegNum:  r_num  <= i_cfg_data[9:0];
                    RegDen:  r_den  <= i_cfg_data[9:0];
                    RegHold: r_hold <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd   <= s_axis_tdata[1:0];
                r_now   <= s_axis_tdata[33:2];
                r_nb[0] <= s_axis_tdata[49:34];
                r_nb[1] <= s_axis_tdata[65:50];
                r_nb[2] <= s_axis_tdata[81:66];
                r_nb[3] <= s_axis_tdata[97:82];
                r_lab   <= s_axis_tdata[101:98];
                r_idx   <= '0;
                r_kept  <= '0;
                r_nemit <= '0;
                r_odata <= {69'd0, StCleared};
                r_olast <= 1'b1;
            end
            S_DRD: begin
                r_ma <= 34'(r_nb[2]) - 34'(r_nb[0]);
                r_mb <= 34'(r_nb[3]) - 34'(r_nb[1]);
            end
            S_DWAIT: r_area_n <= 64'(w_prod);
            S_AREA: begin
                r_ovl <= (w_ir > w_il) && (w_ib > w_it);
                r_ma  <= 34'(e_b[2]) - 34'(e_b[0]);
                r_mb  <= 34'(e_b[3]) - 34'(e_b[1]);
            end
            S_INTER: begin
                r_area_e <= 64'(w_prod);
                r_ma     <= 34'(w_ir) - 34'(w_il);
                r_mb     <= 34'(w_ib) - 34'(w_it);
            end
            S_MUL1: begin
                r_inter <= 64'(w_prod);
                r_ma    <= 34'(w_prod);
                r_mb    <= {24'd0, r_den};
            end
            S_MUL2: begin
                r_lhs <= 64'(w_prod);
                r_ma  <= {24'd0, r_num};
                r_mb  <= 34'(w_union);
            end
            S_DEC: if (!w_match) r_idx <= r_idx + 1'b1;
            S_DWR: begin
                if (r_idx < r_count)                    r_odata <= {69'd0, StMerged};
                else if (r_count != CntW'(MaxRegions)) r_odata <= {69'd0, StInserted};
                else                                    r_odata <= {69'd0, StDropped};
            end
            S_SCHK: begin
                r_idx <= r_idx + 1'b1;
                if (w_keep) r_kept <= r_kept + 1'b1;
            end
            S_EMIT: begin
                if (r_kept == '0) r_odata <= {69'd0, StEmpty};
            end
            S_EWAIT: begin
                // r_count already holds the number of survivors here.
                r_odata <= {1'b0, e_lab, e_b[3], e_b[2], e_b[1], e_b[0], StRegion};
                r_olast <= (r_nemit + 1'b1 == r_count);
                r_nemit <= r_nemit + 1'b1;
            end
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxRegions)) else $error("count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while output held");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed under stall");
endmodule

FILE: hdl/sbt_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module sbt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: sim/tb_sticky_box_tracker_iou_ttl.sv
// Testbench for the sticky box tracker: drives detection, sweep, clear and unused
// command items with random idling and stalls, predicts every result and checks each
// one field by field. Depends on sbt_pkg and the sticky_box_tracker_iou_ttl RTL.

class t_box_table_board;
    logic signed [15:0] bnd [16][4];
    logic [3:0]         lbl [16];
    logic [31:0]        seen [16];
    int                 cnt;
    logic [9:0]         num, den;
    logic [31:0]        hold;
    logic [71:0]        pend_data [$];
    logic               pend_last [$];
    int                 errors;

    function new();
        cnt = 0; num = 3; den = 10; hold = 2500; errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
        if (idx == sbt_pkg::RegNum) num = v[9:0];
        else if (idx == sbt_pkg::RegDen) den = v[9:0];
        else if (idx == sbt_pkg::RegHold) hold = v;
    endfunction

    function void push(logic [2:0] st, logic signed [15:0] b [4], logic [3:0] l,
                       bit with_box, logic last);
        logic [71:0] d;
        d = '0;
        d[2:0] = st;
        if (with_box) begin
            d[18:3] = b[0]; d[34:19] = b[1]; d[50:35] = b[2]; d[66:51] = b[3];
            d[70:67] = l;
        end
        pend_data = {pend_data, d};
        pend_last = {pend_last, last};
    endfunction

    function bit overlaps(logic signed [15:0] a [4], logic signed [15:0] b [4]);
        longint il, it, ir, ib, inter, aa, ab, un;
        il = (a[0] > b[0]) ? a[0] : b[0];
        it = (a[1] > b[1]) ? a[1] : b[1];
        ir = (a[2] < b[2]) ? a[2] : b[2];
        ib = (a[3] < b[3]) ? a[3] : b[3];
        if (ir <= il || ib <= it) return 0;
        inter = (ir - il) * (ib - it);
        aa = (longint'(a[2]) - a[0]) * (longint'(a[3]) - a[1]);
        ab = (longint'(b[2]) - b[0]) * (longint'(b[3]) - b[1]);
        un = aa + ab - inter;
        if (un <= 0) return 0;
        return inter * longint'(den) >= longint'(num) * un;
    endfunction

    // Works out the results of one accepted item and queues them.
    function void note_item(logic [103:0] d);
        logic [1:0]         cmd;
        logic [31:0]        now;
        logic signed [15:0] nb [4];
        logic [3:0]         l;
        int                 kept;
        int                 n;
        cmd = d[1:0]; now = d[33:2];
        nb[0] = d[49:34]; nb[1] = d[65:50]; nb[2] = d[81:66]; nb[3] = d[97:82];
        l = d[101:98];
        if (cmd == sbt_pkg::CmdDetect) begin
            for (int i = 0; i < cnt; i++) begin
                if (overlaps(nb, bnd[i])) begin
                    bnd[i] = nb; lbl[i] = l; seen[i] = now;
                    push(sbt_pkg::StMerged, nb, 0, 0, 1);
                    return;
                end
            end
            if (cnt < 16) begin
                bnd[cnt] = nb; lbl[cnt] = l; seen[cnt] = now; cnt++;
                push(sbt_pkg::StInserted, nb, 0, 0, 1);
            end else begin
                push(sbt_pkg::StDropped, nb, 0, 0, 1);
            end
        end else if (cmd == sbt_pkg::CmdSweep) begin
            kept = 0;
            for (int i = 0; i < cnt; i++) begin
                if (32'(now - seen[i]) > hold) continue;
                bnd[kept] = bnd[i]; lbl[kept] = lbl[i]; seen[kept] = seen[i];
                kept++;
            end
            cnt = kept;
            if (kept == 0) push(sbt_pkg::StEmpty, nb, 0, 0, 1);
            n = (kept > 16) ? 16 : kept;
            for (int i = 0; i < n; i++)
                push(sbt_pkg::StRegion, bnd[i], lbl[i], 1, i + 1 == n);
        end else if (cmd == sbt_pkg::CmdClear) begin
            cnt = 0;
            push(sbt_pkg::StCleared, nb, 0, 0, 1);
        end
    endfunction

    task report(string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    task check_result(logic [71:0] d, logic last);
        logic [71:0] e;
        logic        el;
        if (pend_data.size() == 0) begin
            report($sformatf("unexpected result %h", d));
            return;
        end
        e = pend_data.pop_front();
        el = pend_last.pop_front();
        if (d[2:0] !== e[2:0]) report($sformatf("status %0d want %0d", d[2:0], e[2:0]));
        if (d[18:3] !== e[18:3]) report($sformatf("left %h want %h", d[18:3], e[18:3]));
        if (d[34:19] !== e[34:19]) report($sformatf("top %h want %h", d[34:19], e[34:19]));
        if (d[50:35] !== e[50:35])
            report($sformatf("right %h want %h", d[50:35], e[50:35]));
        if (d[66:51] !== e[66:51])
            report($sformatf("bottom %h want %h", d[66:51], e[66:51]));
        if (d[70:67] !== e[70:67])
            report($sformatf("label %h want %h", d[70:67], e[70:67]));
        if (last !== el) report($sformatf("tlast %b want %b", last, el));
    endtask
endclass

module tb_sticky_box_tracker_iou_ttl;
    import sbt_pkg::*;

    logic         i_clk, i_rst_n;
    logic         s_axis_tvalid, s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid, m_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    t_box_table_board board;
    int  send_idle_pct, stall_pct;
    bit  hold_off;
    int  quiet_cycles;
    logic [31:0] clock_now;

    sticky_box_tracker_iou_ttl DUT (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus one long hold-off when asked.
    always @(negedge i_clk) begin
        if (hold_off) m_axis_tready <= 0;
        else m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tlast);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > 20000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.set_reg(idx, v);
    endtask

    task automatic send_item(logic [1:0] cmd, logic [31:0] t, logic [15:0] l,
                             logic [15:0] tp, logic [15:0] r, logic [15:0] b,
                             logic [3:0] lab);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {2'b0, lab, b, r, tp, l, t, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_item(s_axis_tdata);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pend_data.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    // Mostly small boxes near a few anchors so that merges happen often.
    task automatic random_item();
        int r, x, y, w, h;
        r = $urandom_range(99);
        clock_now += $urandom_range(400);
        x = $urandom_range(3) * 40 + $urandom_range(10);
        y = $urandom_range(3) * 40 + $urandom_range(10);
        w = $urandom_range(40) + 1;
        h = $urandom_range(40) + 1;
        if (r < 70)
            send_item(CmdDetect, clock_now, 16'(x), 16'(y), 16'(x + w), 16'(y + h),
                      4'($urandom));
        else if (r < 80)
            send_item(CmdDetect, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 4'($urandom));
        else if (r < 93)
            send_item(CmdSweep, clock_now, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 4'($urandom));
        else if (r < 97) send_item(CmdClear, $urandom, 0, 0, 0, 0, 0);
        else send_item(2'd3, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 4'($urandom));
    endtask

    initial begin
        board = new();
        i_rst_n = 0; s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
        i_cfg_we = 0; i_cfg_index = '0; i_cfg_data = '0;
        send_idle_pct = 0; stall_pct = 0; hold_off = 0; quiet_cycles = 0;
        clock_now = 1000;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: extremes, inverted boxes, overfill, every command.
        send_item(CmdSweep, 0, 0, 0, 0, 0, 0);
        send_item(CmdDetect, 32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 4'hF);
        send_item(CmdDetect, 5, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 4'h1);
        send_item(CmdDetect, 6, 10, 10, 0, 0, 4'h2);
        send_item(CmdDetect, 7, 0, 0, 10, 10, 4'h3);
        send_item(CmdDetect, 8, 20, 20, 20, 30, 4'h4);
        send_item(2'd3, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
        send_item(CmdSweep, 2000, 0, 0, 0, 0, 0);
        send_item(CmdClear, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 17; i++)
            send_item(CmdDetect, 100, 16'(i * 100), 0, 16'(i * 100 + 50), 50, 4'(i));
        send_item(CmdSweep, 100, 0, 0, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(RegNum, 0); write_reg(RegDen, 1);
                         write_reg(RegHold, 0); end
                1: begin write_reg(RegNum, 1023); write_reg(RegDen, 1023);
                         write_reg(RegHold, 32'hFFFF_FFFF); end
                2: begin write_reg(RegNum, 1); write_reg(RegDen, 2);
                         write_reg(RegHold, 600); end
                3: begin write_reg(RegNum, 5); write_reg(RegDen, 0);
                         write_reg(RegHold, 1500); end
                4: begin write_reg(RegNum, 1023); write_reg(RegDen, 1);
                         write_reg(RegHold, 300); end
                default: begin write_reg(RegNum, 3); write_reg(RegDen, 10);
                         write_reg(RegHold, 2500); end
            endcase
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 53 : (ph == 4 ? 7 : 0);
            stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? 53 : (ph == 4 ? 7 : 0);
            if (ph == 2) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (800) @(negedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int k = 0; k < 48; k++) random_item();
            drain();
        end

        if (board.errors == 0 && board.pend_data.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
